### hdl/i2c_master_byte_sequencer_defines.svh
// Assertion macros shared by the I2C master sequencer modules.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/i2cms_pkg.sv
// Shared types and constants of the I2C master byte sequencer.
`default_nettype none
package i2cms_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_WACK  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_ACK_TIMEOUT = 1'b0,
    CFG_UNIT_TICKS  = 1'b1
  } cfg_idx_e;

  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] UNIT_TICKS_RST  = 16'd1;
  localparam logic [7:0]  MSB_MASK        = 8'h80;

  // Configuration seen by the sequencer core.
  typedef struct packed {
    logic [7:0]  ack_timeout;
    logic [15:0] unit_ticks;
  } cfg_t;

  // One result word before packing.
  typedef struct packed {
    logic       rejected;
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_pull_low;
    logic       scl_level;
  } res_t;

endpackage
`default_nettype wire

### hdl/i2cms_core.sv
// Bus phase sequencer of the I2C master: state and per-word next-state logic.
`default_nettype none
`include "i2c_master_byte_sequencer_defines.svh"
module i2cms_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire i2cms_pkg::cmd_e   cmd_i,
  input  wire logic [7:0]        tx_byte_i,
  input  wire logic              send_ack_i,
  input  wire logic              sda_level_i,
  input  wire i2cms_pkg::cfg_t   cfg_i,
  output i2cms_pkg::res_t        res_o
);

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WACK  = 3'd3,
    OP_SEND  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  localparam logic [2:0] DLY_1 = 3'd1;
  localparam logic [2:0] DLY_2 = 3'd2;
  localparam logic [2:0] DLY_4 = 3'd4;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  op_e         op_q, op_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  wait_q, wait_d;
  logic [15:0] unit_q, unit_d;
  logic [2:0]  dly_q, dly_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic        err_q, err_d;
  logic [7:0]  rx_q, rx_d;
  logic        done, rej;
  logic [15:0] ut;
  logic [16:0] unit_inc;

  // A unit count of zero behaves as one tick per unit.
  assign ut       = (cfg_i.unit_ticks == '0) ? 16'd1 : cfg_i.unit_ticks;
  assign unit_inc = {1'b0, unit_q} + 17'd1;

  // Next state for one accepted word.
  always_comb begin
    op_d      = op_q;
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    unit_d    = unit_q;
    dly_d     = dly_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    ack_d     = ack_q;
    err_d     = err_q;
    rx_d      = rx_q;
    done      = 1'b0;
    rej       = 1'b0;

    case (cmd_i)
      i2cms_pkg::CMD_TICK: begin
        if (op_q != OP_IDLE) begin
          if (dly_q != '0) begin
            // Count ticks of the running delay unit.
            if (unit_inc < {1'b0, ut}) begin
              unit_d = unit_inc[15:0];
            end else begin
              unit_d = '0;
              dly_d  = dly_q - 3'd1;
              if (dly_d == '0) begin
                // The delay has ended: take the next bus step.
                case (op_q)
                  OP_START: begin
                    if (phase_q == 2'd0) begin
                      sda_d = 1'b1; dly_d = DLY_4; phase_d = 2'd1;
                    end else begin
                      scl_d = 1'b0; done = 1'b1;
                    end
                  end
                  OP_STOP: begin
                    if (phase_q == 2'd0) begin
                      scl_d = 1'b1; sda_d = 1'b0; dly_d = DLY_4; phase_d = 2'd1;
                    end else begin
                      done = 1'b1;
                    end
                  end
                  OP_WACK: begin
                    if (phase_q == 2'd0) begin
                      scl_d = 1'b1; dly_d = DLY_1; phase_d = 2'd1;
                    end else begin
                      phase_d = 2'd2;
                    end
                  end
                  OP_SEND: begin
                    if (phase_q == 2'd0) begin
                      scl_d = 1'b1; dly_d = DLY_2; phase_d = 2'd1;
                    end else if (phase_q == 2'd1) begin
                      scl_d = 1'b0; dly_d = DLY_2; phase_d = 2'd2;
                    end else begin
                      bit_idx_d = bit_idx_q + 4'd1;
                      if (bit_idx_d >= BITS_PER_BYTE) begin
                        done = 1'b1;
                      end else begin
                        sda_d   = ~|(shift_q & i2cms_pkg::MSB_MASK);
                        shift_d = {shift_q[6:0], 1'b0};
                        dly_d   = DLY_2;
                        phase_d = 2'd0;
                      end
                    end
                  end
                  OP_READ: begin
                    if (phase_q == 2'd0) begin
                      scl_d = 1'b1; dly_d = DLY_1; phase_d = 2'd1;
                    end else if (phase_q == 2'd1) begin
                      shift_d   = {shift_q[6:0], sda_level_i};
                      bit_idx_d = bit_idx_q + 4'd1;
                      scl_d     = 1'b0;
                      dly_d     = DLY_2;
                      if (bit_idx_d < BITS_PER_BYTE) begin
                        phase_d = 2'd0;
                      end else begin
                        sda_d   = ack_q;
                        phase_d = 2'd2;
                      end
                    end else if (phase_q == 2'd2) begin
                      scl_d = 1'b1; dly_d = DLY_2; phase_d = 2'd3;
                    end else begin
                      scl_d = 1'b0; rx_d = shift_q; done = 1'b1;
                    end
                  end
                  default: done = 1'b1;
                endcase
              end
            end
          end else if (op_q == OP_WACK) begin
            // Poll SDA for the acknowledge.
            if (!sda_level_i) begin
              scl_d = 1'b0; done = 1'b1;
            end else if (wait_q >= cfg_i.ack_timeout) begin
              err_d   = 1'b1;
              op_d    = OP_STOP;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              dly_d   = DLY_4;
              unit_d  = '0;
              phase_d = 2'd0;
            end else begin
              wait_d = wait_q + 8'd1;
            end
          end else begin
            done = 1'b1;
          end
        end
      end
      i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP, i2cms_pkg::CMD_SEND,
      i2cms_pkg::CMD_WACK, i2cms_pkg::CMD_READ: begin
        if (op_q != OP_IDLE) begin
          rej = 1'b1;
        end else begin
          // Launch a new command: every command begins with a delay.
          err_d     = 1'b0;
          bit_idx_d = '0;
          wait_d    = '0;
          unit_d    = '0;
          phase_d   = 2'd0;
          case (cmd_i)
            i2cms_pkg::CMD_START: begin
              op_d = OP_START; sda_d = 1'b0; scl_d = 1'b1; dly_d = DLY_4;
            end
            i2cms_pkg::CMD_STOP: begin
              op_d = OP_STOP; scl_d = 1'b0; sda_d = 1'b1; dly_d = DLY_4;
            end
            i2cms_pkg::CMD_SEND: begin
              op_d    = OP_SEND;
              scl_d   = 1'b0;
              sda_d   = ~|(tx_byte_i & i2cms_pkg::MSB_MASK);
              shift_d = {tx_byte_i[6:0], 1'b0};
              dly_d   = DLY_2;
            end
            i2cms_pkg::CMD_WACK: begin
              op_d = OP_WACK; sda_d = 1'b0; dly_d = DLY_1;
            end
            default: begin
              op_d    = OP_READ;
              sda_d   = 1'b0;
              scl_d   = 1'b0;
              shift_d = '0;
              ack_d   = send_ack_i;
              dly_d   = DLY_2;
            end
          endcase
        end
      end
      default: ;
    endcase

    // A finished command returns to idle.
    if (done) begin
      op_d    = OP_IDLE;
      phase_d = 2'd0;
      dly_d   = '0;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_IDLE;
      phase_q   <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      wait_q    <= '0;
      unit_q    <= '0;
      dly_q     <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b0;
      ack_q     <= 1'b0;
      err_q     <= 1'b0;
      rx_q      <= '0;
    end else if (adv_i) begin
      op_q      <= op_d;
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      wait_q    <= wait_d;
      unit_q    <= unit_d;
      dly_q     <= dly_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      ack_q     <= ack_d;
      err_q     <= err_d;
      rx_q      <= rx_d;
    end
  end

  // Result word shows the state after the word.
  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_pull_low = sda_d;
    res_o.busy         = (op_d != OP_IDLE);
    res_o.done         = done;
    res_o.rx_byte      = rx_d;
    res_o.ack_error    = err_d;
    res_o.rejected     = rej;
  end

  `I2CMS_ASSERT(a_idle_quiet, (op_q == OP_IDLE) |-> (dly_q == '0 && phase_q == 2'd0), "idle with delay or phase pending")
  `I2CMS_ASSERT(a_delay_pending, (op_q != OP_IDLE && op_q != OP_WACK) |-> (dly_q != '0), "running command without delay")
  `I2CMS_ASSERT(a_bit_range, bit_idx_q <= BITS_PER_BYTE, "bit index beyond a byte")
  `I2CMS_ASSERT(a_done_idle, (adv_i && done) |=> (op_q == OP_IDLE), "finished command left busy")

endmodule
`default_nettype wire

### hdl/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: stream ports, registers, result stage.
//
//   Channel   Direction  Handshake                   Content
//   s_axis    in         s_axis_tvalid/tready        command word (tuser cmd, tdata args)
//   m_axis    out        m_axis_tvalid/tready        one result word per command word
//   cfg       in         cfg_valid/cfg_ready         register index and write data
//
// One word is taken per cycle while m_axis is not stalled; its result is in the output register in the cycle after.
// The output register is the only stage: s_axis_tready is high while it is empty or drained.
// A stalled m_axis holds the result and stops intake; cfg writes are always taken.
// Reset releases SCL and SDA, clears the received byte and loads register defaults.
`default_nettype none
`include "i2c_master_byte_sequencer_defines.svh"
module i2c_master_byte_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
  input  wire logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_level
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] scl_level, [1] sda_pull_low, [2] busy_res,
                                           // [3] done_res, [11:4] rx_byte, [12] ack_error,
                                           // [13] rejected
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  i2cms_pkg::cfg_t cfg_q;
  i2cms_pkg::res_t res_comb, res_q;
  logic            out_valid_q;
  logic            accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
      cfg_q.unit_ticks  <= i2cms_pkg::UNIT_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (i2cms_pkg::cfg_idx_e'(cfg_index_i))
        i2cms_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i[7:0];
        i2cms_pkg::CFG_UNIT_TICKS:  cfg_q.unit_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (accept),
    .cmd_i       (i2cms_pkg::cmd_e'(s_axis_tuser)),
    .tx_byte_i   (s_axis_tdata[7:0]),
    .send_ack_i  (s_axis_tdata[8]),
    .sda_level_i (s_axis_tdata[9]),
    .cfg_i       (cfg_q),
    .res_o       (res_comb)
  );

  // Output register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.rejected, res_q.ack_error, res_q.rx_byte,
                          res_q.done, res_q.busy, res_q.sda_pull_low, res_q.scl_level};

  `I2CMS_ASSERT(a_accept_shows, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "accepted word gave no result")
  `I2CMS_ASSERT(a_done_not_busy, (m_axis_tvalid && res_q.done) |-> !res_q.busy, "finished word still busy")
  `I2CMS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result shown during reset")

endmodule
`default_nettype wire
